[sv/sgt_pkg.sv]
// ----------------------------------------------------------------------------
// sgt_pkg: shared types, sizes and functions of the segment tree.
// Holds the tree geometry, the operation codes and the combining functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgt_pkg;

	localparam int LEAVES     = 1024;
	localparam int VALUE_BITS = 32;
	localparam int NODES      = 2 * LEAVES;
	localparam int NODE_AW    = $clog2(NODES);
	localparam int POS_W      = NODE_AW + 1;
	localparam int INDEX_W    = 10;
	localparam int BOUND_W    = 11;
	localparam int DATA_W     = 32;

	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [NODE_AW-1:0]    addr_t;
	typedef logic [VALUE_BITS-1:0] val_t;

	localparam pos_t LEAVES_P = POS_W'(LEAVES);

	typedef enum logic [1:0] {
		MODE_SUM = 2'd0,
		MODE_MIN = 2'd1,
		MODE_MAX = 2'd2,
		MODE_XOR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_UPDATE  = 3'd0,
		OP_QUERY   = 3'd1,
		OP_READ    = 3'd2,
		OP_SET     = 3'd3,
		OP_REBUILD = 3'd4,
		OP_NOP     = 3'd7
	} op_t;

	// One classified word as it waits between front and back.
	typedef struct packed {
		op_t  op;
		logic err;
		pos_t left;
		pos_t right;
		val_t value;
	} item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_CMB,
		ST_QRY,
		ST_LEAF_RD,
		ST_REB_A,
		ST_REB_B,
		ST_REB_C
	} state_t;

	function automatic val_t identity_of(mode_t mode);
		return (mode == MODE_MIN) ? {VALUE_BITS{1'b1}} : '0;
	endfunction

	function automatic val_t combine(mode_t mode, val_t a, val_t b);
		val_t r;
		unique case (mode)
			MODE_SUM: r = a + b;
			MODE_MIN: r = (a < b) ? a : b;
			MODE_MAX: r = (a > b) ? a : b;
			MODE_XOR: r = a ^ b;
			default:  r = a ^ b;
		endcase
		return r;
	endfunction

endpackage

[sv/segment_tree_range_reduce.sv]
// ----------------------------------------------------------------------------
// segment_tree_range_reduce: segment tree with point update and range reduce.
// Top level joining the input queue and the tree engine.
// ----------------------------------------------------------------------------
// The block handles one word at a time on a node memory of 2048 words with
// one write port and one registered read port. An update writes the leaf,
// then fetches the sibling and writes the parent for each tree level; a
// query fetches nodes and climbs the tree a level at a time; a rebuild
// reads both children of each internal node and writes the node. After
// reset and after every write of operation_mode the memory is cleared to
// the identity of the mode, during which in_stall is high. Words wait in a
// two-entry queue while the engine is busy; a finished result waits in the
// output register, and the engine starts the next word only once that
// result has been taken.
`timescale 1ns / 1ps

module segment_tree_range_reduce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    operation_mode,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    op,
	input  logic [sgt_pkg::INDEX_W-1:0]   index,
	input  logic [sgt_pkg::BOUND_W-1:0]   right_bound,
	input  logic [sgt_pkg::DATA_W-1:0]    value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sgt_pkg::DATA_W-1:0]    result_value,
	output logic                          error
);

	logic           clearing;
	logic           q_valid;
	logic           q_pop;
	sgt_pkg::item_t q_item;

	assign cfg_ready = 1'b1;

	sgt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.index       (index),
		.right_bound (right_bound),
		.value       (value),
		.clearing    (clearing),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	sgt_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_mode     (operation_mode),
		.clearing     (clearing),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.error        (error)
	);

endmodule

[sv/sgt_front.sv]
// ----------------------------------------------------------------------------
// sgt_front: input stage of the segment tree.
// Accepts words, decodes the operation, checks bounds and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   op,
	input  logic [sgt_pkg::INDEX_W-1:0]  index,
	input  logic [sgt_pkg::BOUND_W-1:0]  right_bound,
	input  logic [sgt_pkg::DATA_W-1:0]   value,
	input  logic                         clearing,
	output logic                         q_valid,
	output sgt_pkg::item_t               q_item,
	input  logic                         q_pop
);

	sgt_pkg::item_t cls;
	sgt_pkg::item_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	// Decode the operation and check the index and bounds.
	always_comb begin
		cls.left  = sgt_pkg::POS_W'(index);
		cls.right = sgt_pkg::POS_W'(right_bound);
		cls.value = sgt_pkg::VALUE_BITS'(value);
		cls.err   = 1'b0;
		unique case (op)
			3'd0: begin
				cls.op  = sgt_pkg::OP_UPDATE;
				cls.err = cls.left >= sgt_pkg::LEAVES_P;
			end
			3'd1: begin
				cls.op  = sgt_pkg::OP_QUERY;
				cls.err = (cls.left > sgt_pkg::LEAVES_P) || (cls.right > sgt_pkg::LEAVES_P);
			end
			3'd2: begin
				cls.op  = sgt_pkg::OP_READ;
				cls.err = cls.left >= sgt_pkg::LEAVES_P;
			end
			3'd3: begin
				cls.op  = sgt_pkg::OP_SET;
				cls.err = cls.left >= sgt_pkg::LEAVES_P;
			end
			3'd4: cls.op = sgt_pkg::OP_REBUILD;
			default: cls.op = sgt_pkg::OP_NOP;
		endcase
	end

	assign in_stall = clearing || (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = count_q != 2'd0;
	assign pop      = q_pop && q_valid;
	assign q_item   = fifo_q[rd_ptr_q];

	// Two-entry queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

endmodule

[sv/sgt_engine.sv]
// ----------------------------------------------------------------------------
// sgt_engine: back end of the segment tree.
// Owns the node memory and walks it for each word, one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgt_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [1:0]                    cfg_mode,
	output logic                          clearing,
	input  logic                          q_valid,
	input  sgt_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sgt_pkg::DATA_W-1:0]    result_value,
	output logic                          error
);

	sgt_pkg::state_t state_q, state_n;
	sgt_pkg::mode_t  mode_q;
	sgt_pkg::addr_t  clr_cnt_q, clr_cnt_n;
	sgt_pkg::pos_t   node_q, node_n;
	sgt_pkg::pos_t   rnode_q, rnode_n;
	sgt_pkg::val_t   acc_q, acc_n;
	sgt_pkg::val_t   tmp_q, tmp_n;
	logic            pend_q, pend_n;
	logic            out_valid_q;
	sgt_pkg::val_t   out_val_q;
	logic            out_err_q;

	logic            out_load;
	sgt_pkg::val_t   out_val_n;
	logic            out_err_n;

	sgt_pkg::val_t   mem [sgt_pkg::NODES];
	sgt_pkg::val_t   rdata_q;
	logic            we;
	sgt_pkg::addr_t  waddr;
	sgt_pkg::val_t   wdata;
	sgt_pkg::addr_t  raddr;

	sgt_pkg::pos_t   leaf;
	sgt_pkg::pos_t   parent;
	sgt_pkg::val_t   cmb;
	sgt_pkg::val_t   acc_cur;

	assign clearing     = state_q == sgt_pkg::ST_CLEAR;
	assign out_valid    = out_valid_q;
	assign result_value = sgt_pkg::DATA_W'(out_val_q);
	assign error        = out_err_q;

	assign leaf    = sgt_pkg::LEAVES_P + q_item.left;
	assign parent  = node_q >> 1;
	assign acc_cur = pend_q ? sgt_pkg::combine(mode_q, acc_q, rdata_q) : acc_q;

	// Sequencer: next state, memory port and result load.
	always_comb begin
		state_n   = state_q;
		clr_cnt_n = clr_cnt_q;
		node_n    = node_q;
		rnode_n   = rnode_q;
		acc_n     = acc_q;
		tmp_n     = tmp_q;
		pend_n    = pend_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		out_val_n = '0;
		out_err_n = 1'b0;
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		raddr     = '0;
		cmb       = '0;
		unique case (state_q)
			sgt_pkg::ST_CLEAR: begin
				we        = 1'b1;
				waddr     = clr_cnt_q;
				wdata     = sgt_pkg::identity_of(mode_q);
				clr_cnt_n = clr_cnt_q + 1'b1;
				if (clr_cnt_q == {sgt_pkg::NODE_AW{1'b1}}) state_n = sgt_pkg::ST_IDLE;
			end
			sgt_pkg::ST_IDLE: begin
				if (q_valid && !out_valid_q) begin
					q_pop  = 1'b1;
					if (q_item.err) begin
						out_load  = 1'b1;
						out_err_n = 1'b1;
					end else begin
						unique case (q_item.op)
							sgt_pkg::OP_UPDATE: begin
								we      = 1'b1;
								waddr   = leaf[sgt_pkg::NODE_AW-1:0];
								wdata   = q_item.value;
								node_n  = leaf;
								acc_n   = q_item.value;
								state_n = sgt_pkg::ST_UPD_RD;
							end
							sgt_pkg::OP_QUERY: begin
								node_n  = leaf;
								rnode_n = sgt_pkg::LEAVES_P + q_item.right;
								acc_n   = sgt_pkg::identity_of(mode_q);
								pend_n  = 1'b0;
								state_n = sgt_pkg::ST_QRY;
							end
							sgt_pkg::OP_READ: begin
								raddr   = leaf[sgt_pkg::NODE_AW-1:0];
								state_n = sgt_pkg::ST_LEAF_RD;
							end
							sgt_pkg::OP_SET: begin
								we       = 1'b1;
								waddr    = leaf[sgt_pkg::NODE_AW-1:0];
								wdata    = q_item.value;
								out_load = 1'b1;
							end
							sgt_pkg::OP_REBUILD: begin
								node_n  = sgt_pkg::LEAVES_P - 1'b1;
								state_n = sgt_pkg::ST_REB_A;
							end
							default: out_load = 1'b1;
						endcase
					end
				end
			end
			// Update: fetch the sibling, then write the parent.
			sgt_pkg::ST_UPD_RD: begin
				raddr   = node_q[sgt_pkg::NODE_AW-1:0] ^ sgt_pkg::addr_t'(1);
				state_n = sgt_pkg::ST_UPD_CMB;
			end
			sgt_pkg::ST_UPD_CMB: begin
				cmb    = sgt_pkg::combine(mode_q, acc_q, rdata_q);
				we     = 1'b1;
				waddr  = parent[sgt_pkg::NODE_AW-1:0];
				wdata  = cmb;
				acc_n  = cmb;
				node_n = parent;
				if (parent == sgt_pkg::pos_t'(1)) begin
					out_load = 1'b1;
					state_n  = sgt_pkg::ST_IDLE;
				end else begin
					state_n = sgt_pkg::ST_UPD_RD;
				end
			end
			// Query: fold the last fetched node, then take one step of the walk.
			sgt_pkg::ST_QRY: begin
				acc_n = acc_cur;
				if (node_q >= rnode_q) begin
					out_load  = 1'b1;
					out_val_n = acc_cur;
					state_n   = sgt_pkg::ST_IDLE;
				end else if (node_q[0]) begin
					raddr  = node_q[sgt_pkg::NODE_AW-1:0];
					node_n = node_q + 1'b1;
					pend_n = 1'b1;
				end else if (rnode_q[0]) begin
					raddr   = sgt_pkg::NODE_AW'(rnode_q - 1'b1);
					rnode_n = rnode_q - 1'b1;
					pend_n  = 1'b1;
				end else begin
					node_n  = node_q >> 1;
					rnode_n = rnode_q >> 1;
					pend_n  = 1'b0;
				end
			end
			sgt_pkg::ST_LEAF_RD: begin
				out_load  = 1'b1;
				out_val_n = rdata_q;
				state_n   = sgt_pkg::ST_IDLE;
			end
			// Rebuild: read both children, write the node, move down one.
			sgt_pkg::ST_REB_A: begin
				raddr   = sgt_pkg::NODE_AW'(node_q << 1);
				state_n = sgt_pkg::ST_REB_B;
			end
			sgt_pkg::ST_REB_B: begin
				raddr   = sgt_pkg::NODE_AW'((node_q << 1) | sgt_pkg::pos_t'(1));
				tmp_n   = rdata_q;
				state_n = sgt_pkg::ST_REB_C;
			end
			sgt_pkg::ST_REB_C: begin
				we    = 1'b1;
				waddr = node_q[sgt_pkg::NODE_AW-1:0];
				wdata = sgt_pkg::combine(mode_q, tmp_q, rdata_q);
				if (node_q == sgt_pkg::pos_t'(1)) begin
					out_load = 1'b1;
					state_n  = sgt_pkg::ST_IDLE;
				end else begin
					node_n  = node_q - 1'b1;
					state_n = sgt_pkg::ST_REB_A;
				end
			end
			default: state_n = sgt_pkg::ST_IDLE;
		endcase
		// A mode write restarts the clearing pass.
		if (cfg_valid) begin
			state_n   = sgt_pkg::ST_CLEAR;
			clr_cnt_n = '0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sgt_pkg::ST_CLEAR;
			mode_q      <= sgt_pkg::MODE_SUM;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			clr_cnt_q <= clr_cnt_n;
			if (cfg_valid) mode_q <= sgt_pkg::mode_t'(cfg_mode);
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		node_q  <= node_n;
		rnode_q <= rnode_n;
		acc_q   <= acc_n;
		tmp_q   <= tmp_n;
		pend_q  <= pend_n;
		if (out_load) begin
			out_val_q <= out_val_n;
			out_err_q <= out_err_n;
		end
	end

	// Node memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

endmodule
